[rtl/qwd_pkg.sv]
// shared constants, types and command/status structs for the query word dedup block
// no dependencies

package qwd_pkg;

	localparam int SLOT_BITS = 16;
	localparam int SLOT_COUNT = 1 << SLOT_BITS;
	localparam int MAX_WORDS = 4096;
	localparam int LIST_AW = $clog2(MAX_WORDS);
	localparam int CNT_W = $clog2(MAX_WORDS + 1);
	localparam int OUT_W = 32;

	typedef logic [SLOT_BITS-1:0] slot_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic init_step;
		logic load;
		logic commit;
		logic walk;
	} dp_cmd_t;

	typedef struct packed {
		logic init_last;
		logic out_free;
		logic walk_done;
		logic item_last;
	} dp_status_t;

endpackage

[rtl/query_word_dedup.sv]
// query word dedup top level: controller plus datapath
// result path: a request is latched, its seen bit read, its result registered once the
// output register has room; the next word is taken only after that commit, and after a
// last word a walk over the unique list (single read port) clears the seen bitmap
// reset: after arst_n is released a clearing pass writes all 65536 seen bits, one per
// cycle, and s_tready stays low until that pass is done

module query_word_dedup (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [15:0] word_index
	input  logic        s_tlast,  // last_word
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [15:0] out_word, [16] first_seen, [29:17] unique_count,
	                              // [30] overflow, [31] zero
	output logic        m_tlast   // query_end
);
	import qwd_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	qwd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	qwd_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.in_word  (slot_t'(s_tdata)),
		.in_last  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// a result never overwrites one that has not been taken
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> status.out_free)
		else $error("commit while output register is occupied");

	// no new request while the seen bits are being cleared
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.walk || cmd.init_step) |-> !s_tready)
		else $error("request accepted during clearing");

	// unique count stays within the list capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[29:17] <= 13'(MAX_WORDS)))
		else $error("unique count above list capacity");

	// a first occurrence always counts itself
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[16]) |-> (m_tdata[29:17] != 13'd0))
		else $error("first occurrence with zero count");

endmodule

[rtl/qwd_ctrl.sv]
// controller state machine: power-up clear, lookup/commit, clearing walk
// depends on qwd_pkg

module qwd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  qwd_pkg::dp_status_t status,
	output qwd_pkg::dp_cmd_t    cmd
);
	import qwd_pkg::*;

	localparam logic [1:0] ST_INIT = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_LOOK = 2'd2;
	localparam logic [1:0] ST_WALK = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		cmd = '0;
		s_tready = 1'b0;
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				cmd.init_step = 1'b1;
				if (status.init_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				// seen bit is ready; wait for room in the output register
				if (status.out_free) begin
					cmd.commit = 1'b1;
					state_d = status.item_last ? ST_WALK : ST_IDLE;
				end
			end
			ST_WALK: begin
				cmd.walk = 1'b1;
				if (status.walk_done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/qwd_dp.sv]
// datapath: seen bitmap, unique word list, counters and output register
// depends on qwd_pkg

module qwd_dp (
	input  logic                     clk,
	input  logic                     arst_n,
	input  qwd_pkg::dp_cmd_t          cmd,
	output qwd_pkg::dp_status_t       status,
	input  qwd_pkg::slot_t            in_word,
	input  logic                     in_last,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [qwd_pkg::OUT_W-1:0] m_tdata,
	output logic                     m_tlast
);
	import qwd_pkg::*;

	logic  seen_mem [SLOT_COUNT];
	slot_t list_mem [MAX_WORDS];

	slot_t word_q;
	logic  last_q;
	logic  seen_rd_q;
	slot_t list_rd_q;
	slot_t init_addr_q;
	cnt_t  total_q;
	cnt_t  clr_idx_q;
	logic  ovf_q;
	logic  clr_pend_q;

	logic  out_valid_q;
	slot_t out_word_q;
	logic  out_first_q;
	cnt_t  out_cnt_q;
	logic  out_last_q;
	logic  out_ovf_q;

	slot_t seen_raddr;
	logic  seen_we;
	slot_t seen_waddr;
	logic  seen_wdata;
	logic  is_new;
	logic  room;
	logic  record;
	cnt_t  total_nx;
	logic  ovf_nx;
	logic  walk_done;
	logic  walk_issue;
	logic  out_free;

	assign is_new = !seen_rd_q;
	assign room = (total_q != cnt_t'(MAX_WORDS));
	assign record = is_new && room;
	assign total_nx = record ? total_q + cnt_t'(1) : total_q;
	assign ovf_nx = ovf_q | (is_new & !room);
	assign walk_done = (clr_idx_q == total_q);
	assign walk_issue = cmd.walk && !walk_done;
	assign out_free = !out_valid_q || m_tready;

	// address held on the latched word so the read data stays put while stalled
	assign seen_raddr = cmd.load ? in_word : word_q;

	always_comb begin
		seen_we = 1'b0;
		seen_waddr = word_q;
		seen_wdata = 1'b1;
		if (cmd.init_step) begin
			seen_we = 1'b1;
			seen_waddr = init_addr_q;
			seen_wdata = 1'b0;
		end else if (clr_pend_q) begin
			seen_we = 1'b1;
			seen_waddr = list_rd_q;
			seen_wdata = 1'b0;
		end else if (cmd.commit && record) begin
			seen_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (seen_we) begin
			seen_mem[seen_waddr] <= seen_wdata;
		end
		seen_rd_q <= seen_mem[seen_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && record) begin
			list_mem[total_q[LIST_AW-1:0]] <= word_q;
		end
		list_rd_q <= list_mem[clr_idx_q[LIST_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			word_q <= in_word;
			last_q <= in_last;
		end
		if (cmd.commit) begin
			out_word_q <= word_q;
			out_first_q <= record;
			out_cnt_q <= total_nx;
			out_last_q <= last_q;
			out_ovf_q <= ovf_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_addr_q <= '0;
			total_q <= '0;
			clr_idx_q <= '0;
			ovf_q <= 1'b0;
			clr_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.init_step) begin
				init_addr_q <= init_addr_q + slot_t'(1);
			end
			clr_pend_q <= walk_issue;
			if (cmd.commit) begin
				total_q <= total_nx;
				ovf_q <= ovf_nx;
			end else if (walk_issue) begin
				clr_idx_q <= clr_idx_q + cnt_t'(1);
			end else if (cmd.walk) begin
				// last pending clear goes out this cycle
				clr_idx_q <= '0;
				total_q <= '0;
				ovf_q <= 1'b0;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.init_last = (init_addr_q == slot_t'(SLOT_COUNT - 1));
	assign status.out_free = out_free;
	assign status.walk_done = walk_done;
	assign status.item_last = last_q;

	assign m_tvalid = out_valid_q;
	assign m_tlast = out_last_q;
	assign m_tdata = {1'b0, out_ovf_q, out_cnt_q, out_first_q, out_word_q};

endmodule
